@@ rtl/bes_pkg.sv @@
// Shared types, register codes and action codes for the button and encoder settings menu.
package bes_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS = 3'd1;
    localparam logic [2:0] REG_PARAM_CNT  = 3'd2;
    localparam logic [2:0] REG_FORM_CNT   = 3'd3;
    localparam logic [2:0] REG_PRESET_CNT = 3'd4;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd500;
    localparam logic [2:0]  PARAM_CNT_RST  = 3'd4;
    localparam logic [2:0]  FORM_CNT_RST   = 3'd3;
    localparam logic [2:0]  PRESET_CNT_RST = 3'd4;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_PAUSE = 2'd3;

    localparam logic [1:0] PARAM_MINUTES = 2'd0;
    localparam logic [1:0] PARAM_SECONDS = 2'd1;
    localparam logic [1:0] PARAM_FORM    = 2'd2;
    localparam logic [1:0] PARAM_PRESET  = 2'd3;

    localparam logic [5:0] MINUTE_MAX     = 6'd59;
    localparam logic [5:0] SECOND_MAX     = 6'd59;
    localparam logic [5:0] SECOND_MIN     = 6'd10;
    localparam logic [5:0] SECOND_RST     = 6'd10;
    localparam logic [2:0] WRAP_VALUE_RST = 3'd1;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [2:0]  param_count;
        logic [2:0]  form_count;
        logic [2:0]  preset_count;
    } t_cfg;

    typedef struct packed {
        logic        button_released;
        logic [31:0] time_ms;
        logic signed [31:0] encoder_count;
        logic        tilt_positive;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic        menu_active;
        logic [1:0]  selected_param;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [2:0]  form;
        logic [2:0]  preset;
        logic [11:0] total_seconds;
        logic        orientation;
        logic        orientation_changed;
        logic        redraw_menu;
    } t_out_item;

endpackage

@@ rtl/bes_cfg.sv @@
// Configuration register file behind the APB-style port.
module bes_cfg
    import bes_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_DEBOUNCE:   n_cfg.debounce_ms   = pwdata[15:0];
                REG_LONG_PRESS: n_cfg.long_press_ms = pwdata[15:0];
                REG_PARAM_CNT:  n_cfg.param_count   = pwdata[2:0];
                REG_FORM_CNT:   n_cfg.form_count    = pwdata[2:0];
                REG_PRESET_CNT: n_cfg.preset_count  = pwdata[2:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE:   prdata = {16'd0, r_cfg.debounce_ms};
            REG_LONG_PRESS: prdata = {16'd0, r_cfg.long_press_ms};
            REG_PARAM_CNT:  prdata = {29'd0, r_cfg.param_count};
            REG_FORM_CNT:   prdata = {29'd0, r_cfg.form_count};
            REG_PRESET_CNT: prdata = {29'd0, r_cfg.preset_count};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
            r_cfg.param_count   <= PARAM_CNT_RST;
            r_cfg.form_count    <= FORM_CNT_RST;
            r_cfg.preset_count  <= PRESET_CNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/bes_core.sv @@
// Button timing, menu state and encoder value update for one poll.
module bes_core
    import bes_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [31:0] r_mark,    n_mark;
    logic        r_armed,   n_armed;
    logic        r_long,    n_long;
    logic        r_menu,    n_menu;
    logic [1:0]  r_param,   n_param;
    logic [5:0]  r_minute,  n_minute;
    logic [5:0]  r_second,  n_second;
    logic [2:0]  r_form,    n_form;
    logic [2:0]  r_preset,  n_preset;
    logic [31:0] r_last,    n_last;
    logic        r_side;

    // Next form or preset value, wrapping between 1 and the clamped count.
    function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic up,
                                             input logic [2:0] cnt);
        logic [2:0] c;
        logic [3:0] inc;
        c   = (cnt == 3'd0) ? 3'd1 : cnt;
        inc = {1'b0, v} + 4'd1;
        if (up) begin
            wrap_step = (inc > {1'b0, c}) ? 3'd1 : inc[2:0];
        end else begin
            wrap_step = (v <= 3'd1) ? c : v - 3'd1;
        end
    endfunction

    // Next parameter index: (p + 1) modulo the count clamped to one through four.
    function automatic logic [1:0] param_step(input logic [1:0] p, input logic [2:0] cnt);
        logic [2:0] s;
        s = {1'b0, p} + 3'd1;
        case (cnt)
            3'd0, 3'd1: param_step = 2'd0;
            3'd2:       param_step = {1'b0, s[0]};
            3'd3:       param_step = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
            default:    param_step = s[1:0];
        endcase
    endfunction

    logic [31:0] elapsed;
    logic        deb_over;
    logic        long_over;
    logic        released;
    logic        turned;
    logic        redraw;
    logic [1:0]  action;
    logic [11:0] total;
    logic [31:0] enc_delta;
    logic        enc_up;
    logic [11:0] min_ext;

    assign released  = i_item.button_released;
    assign elapsed   = i_item.time_ms - r_mark;
    assign deb_over  = elapsed > {16'd0, i_cfg.debounce_ms};
    assign long_over = elapsed > {16'd0, i_cfg.long_press_ms};
    assign turned    = r_side != i_item.tilt_positive;
    assign enc_delta = i_item.encoder_count - r_last;
    assign min_ext   = {6'd0, r_minute};

    // A step of +1 counts up, -1 down; any larger jump counts against its sign (negative counts up).
    always_comb begin
        if (enc_delta == 32'd1) begin
            enc_up = 1'b1;
        end else if (enc_delta == 32'hFFFF_FFFF) begin
            enc_up = 1'b0;
        end else begin
            enc_up = enc_delta[31];
        end
    end

    always_comb begin
        n_mark   = r_mark;
        n_armed  = r_armed;
        n_long   = r_long;
        n_menu   = r_menu;
        n_param  = r_param;
        n_minute = r_minute;
        n_second = r_second;
        n_form   = r_form;
        n_preset = r_preset;
        n_last   = r_last;
        action   = ACT_NONE;
        total    = 12'd0;
        redraw   = turned && r_menu;

        if (!released && !r_armed && deb_over) begin
            n_armed = 1'b1;
            n_long  = 1'b0;
            n_mark  = i_item.time_ms;
        end else if (!released && !r_long && long_over) begin
            n_long = 1'b1;
            n_menu = !r_menu;
            if (!r_menu) begin
                action = ACT_STOP;
                redraw = 1'b1;
            end else begin
                action = ACT_START;
                total  = (min_ext << 6) - (min_ext << 2) + {6'd0, r_second};
            end
        end else if (released && r_armed && deb_over) begin
            n_armed = 1'b0;
            n_mark  = i_item.time_ms;
            if (!r_long) begin
                if (r_menu) begin
                    n_param = param_step(r_param, i_cfg.param_count);
                    redraw  = 1'b1;
                end else begin
                    action = ACT_PAUSE;
                end
            end
        end

        if (n_menu && (i_item.encoder_count != r_last)) begin
            case (n_param)
                PARAM_MINUTES: begin
                    if (enc_up) begin
                        n_minute = (r_minute == MINUTE_MAX) ? 6'd0 : r_minute + 6'd1;
                    end else begin
                        n_minute = (r_minute == 6'd0) ? MINUTE_MAX : r_minute - 6'd1;
                    end
                    if (n_minute == 6'd0 && r_second < SECOND_MIN) begin
                        n_second = SECOND_MIN;
                    end
                end
                PARAM_SECONDS: begin
                    if (enc_up) begin
                        n_second = (r_second == SECOND_MAX) ? 6'd0 : r_second + 6'd1;
                    end else begin
                        n_second = (r_second == 6'd0) ? SECOND_MAX : r_second - 6'd1;
                    end
                    // hold the total at ten seconds or more
                    if (r_minute == 6'd0 && n_second < SECOND_MIN) begin
                        n_second = enc_up ? SECOND_MIN : SECOND_MAX;
                    end
                end
                PARAM_FORM: n_form = wrap_step(r_form, enc_up, i_cfg.form_count);
                default:    n_preset = wrap_step(r_preset, enc_up, i_cfg.preset_count);
            endcase
            redraw = 1'b1;
            n_last = i_item.encoder_count;
        end
    end

    always_comb begin
        o_result.action              = action;
        o_result.menu_active         = n_menu;
        o_result.selected_param      = n_param;
        o_result.minutes             = n_minute;
        o_result.seconds             = n_second;
        o_result.form                = n_form;
        o_result.preset              = n_preset;
        o_result.total_seconds       = total;
        o_result.orientation         = i_item.tilt_positive;
        o_result.orientation_changed = turned;
        o_result.redraw_menu         = redraw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark   <= '0;
            r_armed  <= 1'b0;
            r_long   <= 1'b0;
            r_menu   <= 1'b0;
            r_param  <= PARAM_MINUTES;
            r_minute <= '0;
            r_second <= SECOND_RST;
            r_form   <= WRAP_VALUE_RST;
            r_preset <= WRAP_VALUE_RST;
            r_last   <= '0;
            r_side   <= 1'b0;
        end else if (i_en) begin
            r_mark   <= n_mark;
            r_armed  <= n_armed;
            r_long   <= n_long;
            r_menu   <= n_menu;
            r_param  <= n_param;
            r_minute <= n_minute;
            r_second <= n_second;
            r_form   <= n_form;
            r_preset <= n_preset;
            r_last   <= n_last;
            r_side   <= i_item.tilt_positive;
        end
    end

endmodule

@@ rtl/button_encoder_settings_menu.sv @@
// Top level: poll input register, settings menu core, result register and config port.
//
// One poll beat on the input channel (i_in_valid / o_in_stall, payload i_in_data)
// gives exactly one result beat on the output channel (o_out_valid / i_out_stall,
// payload o_out_data). A poll is accepted when valid is high and stall is low.
// An accepted poll goes through the input register, then through the core into the
// result register that drives o_out_data. Throughput is one poll per cycle unless
// the receiver stalls; the core's state update is one pass of compare-and-update
// logic between the two registers. When the receiver stalls, the result register
// holds its beat and the input register takes one more poll; after that o_in_stall
// rises until the stall ends. Synchronous active-low reset empties both registers
// and sets the menu state and the configuration registers to their defaults. The
// APB-style port writes configuration (register i at byte address 4*i); the user
// must write it only while no poll is in flight, which the block does not enforce.
module button_encoder_settings_menu
    import bes_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item core_result;
    logic      out_free;
    logic      advance;
    logic      in_take;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bes_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bes_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on a taken beat, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

endmodule

@@ sim/button_encoder_settings_menu_tb.sv @@
// Self-checking testbench for the button, encoder and tilt settings menu block.
`timescale 1ns / 100ps

module button_encoder_settings_menu_tb;
    import bes_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_POLLS    = 215;
    localparam int PHASE_COUNT    = 7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    button_encoder_settings_menu u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the configuration and of the menu state
    logic [15:0] cfg_debounce = DEBOUNCE_RST;
    logic [15:0] cfg_long     = LONG_PRESS_RST;
    logic [2:0]  cfg_params   = PARAM_CNT_RST;
    logic [2:0]  cfg_forms    = FORM_CNT_RST;
    logic [2:0]  cfg_presets  = PRESET_CNT_RST;

    logic [31:0] press_mark   = '0;
    logic        armed        = 1'b0;
    logic        long_seen    = 1'b0;
    logic        in_menu      = 1'b0;
    logic [1:0]  param_sel    = PARAM_MINUTES;
    logic [5:0]  minute_val   = '0;
    logic [5:0]  second_val   = SECOND_RST;
    logic [2:0]  form_val     = WRAP_VALUE_RST;
    logic [2:0]  preset_val   = WRAP_VALUE_RST;
    logic [31:0] enc_seen     = '0;
    logic        tilt_seen    = 1'b0;

    t_in_item  poll_queue[$];
    t_out_item result_queue[$];

    int  polls_made   = 0;
    int  polls_taken  = 0;
    int  fail_count   = 0;
    int  idle_cycles  = 0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  hold_req     = 0;
    int  hold_served  = 0;
    int  hold_left    = 0;
    bit  calm         = 1'b0;
    logic in_beat_taken = 1'b0;

    // Stimulus generator position
    logic [31:0] gen_time = '0;
    logic [31:0] gen_enc  = '0;
    logic        gen_tilt = 1'b0;

    function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic up,
                                             input logic [2:0] count);
        logic [2:0] top;
        logic [3:0] nxt;
        top = (count == 3'd0) ? 3'd1 : count;
        if (up) begin
            nxt = {1'b0, v} + 4'd1;
            return (nxt > {1'b0, top}) ? 3'd1 : nxt[2:0];
        end
        return (v <= 3'd1) ? top : v - 3'd1;
    endfunction

    task automatic advance_menu(input t_in_item p, output t_out_item r);
        logic [31:0] elapsed;
        logic [31:0] delta;
        logic        up;
        logic [2:0]  pcount;
        int          tmp;
        r = '0;
        if (tilt_seen != p.tilt_positive) begin
            tilt_seen = p.tilt_positive;
            r.orientation_changed = 1'b1;
            if (in_menu) r.redraw_menu = 1'b1;
        end

        elapsed = p.time_ms - press_mark;
        if (!p.button_released && !armed && elapsed > cfg_debounce) begin
            armed = 1'b1;
            long_seen = 1'b0;
            press_mark = p.time_ms;
        end else if (!p.button_released && !long_seen && elapsed > cfg_long) begin
            long_seen = 1'b1;
            in_menu = !in_menu;
            if (in_menu) begin
                r.action = ACT_STOP;
                r.redraw_menu = 1'b1;
            end else begin
                r.action = ACT_START;
                tmp = minute_val * 60 + second_val;
                r.total_seconds = tmp[11:0];
            end
        end else if (p.button_released && armed && elapsed > cfg_debounce) begin
            armed = 1'b0;
            press_mark = p.time_ms;
            if (!long_seen) begin
                if (in_menu) begin
                    pcount = (cfg_params == 3'd0) ? 3'd1 :
                             (cfg_params > 3'd4) ? 3'd4 : cfg_params;
                    tmp = (param_sel + 1) % pcount;
                    param_sel = tmp[1:0];
                    r.redraw_menu = 1'b1;
                end else begin
                    r.action = ACT_PAUSE;
                end
            end
        end

        if (in_menu && p.encoder_count != enc_seen) begin
            delta = p.encoder_count - enc_seen;
            // A single step counts as itself, any larger jump is read backwards
            if (delta == 32'd1) up = 1'b1;
            else if (delta == '1) up = 1'b0;
            else up = delta[31];
            case (param_sel)
                PARAM_MINUTES: begin
                    if (up) minute_val = (minute_val == MINUTE_MAX) ? 6'd0 : minute_val + 6'd1;
                    else minute_val = (minute_val == 6'd0) ? MINUTE_MAX : minute_val - 6'd1;
                    if (minute_val == 6'd0 && second_val < SECOND_MIN) second_val = SECOND_MIN;
                end
                PARAM_SECONDS: begin
                    if (up) second_val = (second_val == SECOND_MAX) ? 6'd0 : second_val + 6'd1;
                    else second_val = (second_val == 6'd0) ? SECOND_MAX : second_val - 6'd1;
                    if (minute_val == 6'd0 && second_val < SECOND_MIN)
                        second_val = up ? SECOND_MIN : SECOND_MAX;
                end
                PARAM_FORM: form_val = wrap_step(form_val, up, cfg_forms);
                default: preset_val = wrap_step(preset_val, up, cfg_presets);
            endcase
            r.redraw_menu = 1'b1;
            enc_seen = p.encoder_count;
        end

        r.menu_active = in_menu;
        r.selected_param = param_sel;
        r.minutes = minute_val;
        r.seconds = second_val;
        r.form = form_val;
        r.preset = preset_val;
        r.orientation = tilt_seen;
    endtask

    function automatic string fmt_result(input t_out_item r);
        return $sformatf({"act=%0d menu=%0d par=%0d min=%0d sec=%0d form=%0d pre=%0d",
                          " tot=%0d ori=%0d chg=%0d redraw=%0d"},
            r.action, r.menu_active, r.selected_param, r.minutes, r.seconds, r.form,
            r.preset, r.total_seconds, r.orientation, r.orientation_changed, r.redraw_menu);
    endfunction

    // Input beats feed the predictor, output beats are checked against it
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        moved = 1'b0;
        in_beat_taken <= i_rst_n && in_valid && !in_stall;
        if (i_rst_n && in_valid && !in_stall) begin
            advance_menu(in_data, want);
            result_queue.push_back(want);
            polls_taken++;
            moved = 1'b1;
        end
        if (i_rst_n && out_valid && !out_stall) begin
            moved = 1'b1;
            if (result_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: result beat with nothing pending: %s",
                             fmt_result(out_data));
            end else begin
                want = result_queue.pop_front();
                if (out_data.action !== want.action || out_data.menu_active !== want.menu_active ||
                    out_data.selected_param !== want.selected_param ||
                    out_data.minutes !== want.minutes || out_data.seconds !== want.seconds ||
                    out_data.form !== want.form || out_data.preset !== want.preset ||
                    out_data.total_seconds !== want.total_seconds ||
                    out_data.orientation !== want.orientation ||
                    out_data.orientation_changed !== want.orientation_changed ||
                    out_data.redraw_menu !== want.redraw_menu) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ERROR: result beat differs at %0t", $realtime);
                        $display("  exp %s", fmt_result(want));
                        $display("  got %s", fmt_result(out_data));
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Poll driver: hold the beat until taken, insert short gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_beat_taken) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end else if (poll_queue.size() != 0) begin
                in_data <= poll_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(negedge i_clk) begin
        bit burst;
        if (recv_gap != 0) begin
            recv_gap = recv_gap - 1;
            burst = 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 4);
            burst = 1'b1;
        end else begin
            burst = 1'b0;
        end
        out_stall <= burst || (hold_left != 0);
    end

    task automatic push_poll(input logic rel, input logic [31:0] t, input logic [31:0] enc,
                             input logic tilt);
        t_in_item p;
        gen_time = t;
        gen_enc = enc;
        gen_tilt = tilt;
        p.button_released = rel;
        p.time_ms = t;
        p.encoder_count = enc;
        p.tilt_positive = tilt;
        poll_queue.push_back(p);
        polls_made++;
    endtask

    task automatic rand_poll(input logic rel, input int unsigned dt, input logic [31:0] denc);
        logic tilt;
        tilt = ($urandom_range(0, 11) == 0) ? ~gen_tilt : gen_tilt;
        push_poll(rel, gen_time + dt, gen_enc + denc, tilt);
    endtask

    function automatic logic [31:0] turn_amount();
        logic [31:0] k;
        k = $urandom_range(2, 6);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'd1;
            4, 5, 6:    return '1;
            7:          return 32'd0;
            8:          return $urandom_range(0, 1) ? k : -k;
            default:    return $urandom();
        endcase
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEBOUNCE:   cfg_debounce = val[15:0];
            REG_LONG_PRESS: cfg_long = val[15:0];
            REG_PARAM_CNT:  cfg_params = val[2:0];
            REG_FORM_CNT:   cfg_forms = val[2:0];
            REG_PRESET_CNT: cfg_presets = val[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (polls_taken != polls_made || result_queue.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int unsigned deb, lng, hold, part, n;
        int          start;
        logic [15:0] d16, l16;
        logic [2:0]  pc, fc, rc;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence under reset settings
        push_poll(1'b1, 32'd10,   32'd0, 1'b1);          // tilt flip outside the menu
        push_poll(1'b0, 32'd100,  32'd0, 1'b1);          // arm
        push_poll(1'b0, 32'd601,  32'd0, 1'b1);          // long press enters menu
        push_poll(1'b0, 32'd610,  32'd0, 1'b0);          // tilt flip inside the menu
        push_poll(1'b1, 32'd700,  32'd0, 1'b0);          // release after long press
        push_poll(1'b1, 32'd710,  '1,    1'b0);          // minutes wrap down to 59
        push_poll(1'b1, 32'd720,  32'd0, 1'b0);          // minutes back to 0
        push_poll(1'b0, 32'd800,  32'd0, 1'b0);
        push_poll(1'b1, 32'd900,  32'd0, 1'b0);          // select seconds
        push_poll(1'b1, 32'd910,  '1,    1'b0);          // below minimum goes to 59
        push_poll(1'b1, 32'd920,  32'd0, 1'b0);          // wraps up to minimum
        push_poll(1'b1, 32'd930,  32'h7FFF_FFFF, 1'b0);  // big positive jump decrements
        push_poll(1'b1, 32'd940,  32'h8000_0000, 1'b0);  // counter wraps, single step up
        push_poll(1'b0, 32'd1000, 32'h8000_0000, 1'b0);
        push_poll(1'b1, 32'd1100, 32'h8000_0000, 1'b0);  // select form
        push_poll(1'b1, 32'd1110, 32'h8000_0001, 1'b0);
        push_poll(1'b1, 32'd1120, 32'h8000_0000, 1'b0);
        push_poll(1'b1, 32'd1130, 32'h7FFF_FFFF, 1'b0);  // form wraps down to count
        push_poll(1'b0, 32'd1200, 32'h7FFF_FFFF, 1'b0);
        push_poll(1'b1, 32'd1300, 32'h7FFF_FFFF, 1'b0);  // select preset
        push_poll(1'b1, 32'd1310, 32'h7FFF_FFFE, 1'b0);  // preset wraps down
        push_poll(1'b0, 32'hFFFF_FFF0, 32'h7FFF_FFFE, 1'b0);
        push_poll(1'b0, 32'h0000_0210, 32'h7FFF_FFFE, 1'b0); // long press across time wrap
        push_poll(1'b0, 32'h0000_0400, 32'h7FFF_FFFE, 1'b0);
        push_poll(1'b1, 32'h0000_0410, 32'h7FFF_FFFE, 1'b0); // release after long press, no action
        push_poll(1'b1, 32'h0000_0480, 32'h7FFF_FFFE, 1'b0); // release while not armed, no action
        push_poll(1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        wait_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin d16 = 16'd0;     l16 = 16'd0;     pc = 3'd7; fc = 3'd7; rc = 3'd7; end
                1: begin d16 = 16'hFFFF;  l16 = 16'hFFFF;  pc = 3'd0; fc = 3'd0; rc = 3'd0; end
                2: begin d16 = 16'd20;    l16 = 16'd10;    pc = 3'd2; fc = 3'd7; rc = 3'd7; end
                3: begin d16 = 16'd50;    l16 = 16'd500;   pc = 3'd4; fc = 3'd2; rc = 3'd1; end
                4: begin
                    d16 = 16'($urandom_range(0, 16'hFFFF));
                    l16 = 16'($urandom_range(0, 16'hFFFF));
                    pc = 3'($urandom_range(0, 7));
                    fc = 3'($urandom_range(0, 7));
                    rc = 3'($urandom_range(0, 7));
                end
                5: begin
                    d16 = 16'($urandom_range(0, 100));
                    l16 = 16'($urandom_range(0, 600));
                    pc = 3'($urandom_range(1, 4));
                    fc = 3'($urandom_range(1, 7));
                    rc = 3'($urandom_range(1, 7));
                end
                default: begin d16 = 16'd30; l16 = 16'd300; pc = 3'd3; fc = 3'd5; rc = 3'd6; end
            endcase
            cfg_write(REG_DEBOUNCE, {16'd0, d16});
            cfg_write(REG_LONG_PRESS, {16'd0, l16});
            cfg_write(REG_PARAM_CNT, {29'd0, pc});
            cfg_write(REG_FORM_CNT, {29'd0, fc});
            cfg_write(REG_PRESET_CNT, {29'd0, rc});
            // Hold the receiver off so the block backs up into its input
            if (ph == 1 || ph == 4) hold_req++;
            @(posedge i_clk);
            if (ph == PHASE_COUNT - 1) calm = 1'b1;

            deb = {16'd0, cfg_debounce};
            lng = {16'd0, cfg_long};
            start = polls_made;
            while (polls_made - start < PHASE_POLLS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: begin
                        // short press: arm, a few held polls, release before long unless long <= debounce
                        rand_poll(1'b0, deb + 1 + $urandom_range(0, 40), 32'd0);
                        hold = $urandom_range(deb + 1, (lng > deb + 1) ? lng : deb + 1);
                        n = $urandom_range(0, 3);
                        part = hold / (n + 1);
                        repeat (n)
                            rand_poll(1'b0, part,
                                      ($urandom_range(0, 3) == 0) ? turn_amount() : 32'd0);
                        rand_poll(1'b1, hold - n * part, 32'd0);
                    end
                    7, 8, 9, 10: begin
                        // long press toggles the menu
                        rand_poll(1'b0, deb + 1 + $urandom_range(0, 40), 32'd0);
                        n = $urandom_range(1, 4);
                        hold = lng + 1 + $urandom_range(0, 60);
                        part = hold / n;
                        repeat (n - 1)
                            rand_poll(1'b0, part,
                                      ($urandom_range(0, 3) == 0) ? turn_amount() : 32'd0);
                        rand_poll(1'b0, hold - (n - 1) * part, 32'd0);
                        repeat ($urandom_range(0, 2))
                            rand_poll(1'b0, $urandom_range(0, 100), turn_amount());
                        rand_poll(1'b1, deb + 1 + $urandom_range(0, 40), 32'd0);
                    end
                    11, 12, 13, 14, 15, 16: begin
                        repeat ($urandom_range(1, 8))
                            rand_poll(1'b1, $urandom_range(0, 200), turn_amount());
                    end
                    default: begin
                        repeat ($urandom_range(1, 3))
                            push_poll(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                                      1'($urandom_range(0, 1)));
                    end
                endcase
            end
            wait_drained();
        end

        fail_count += result_queue.size();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
